/* rtl/core/svl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_pkg: shared types for the stack of variable-length lists
// Operation and status codes plus the payload structs of both channels.
// ----------------------------------------------------------------------------
package svl_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_VALUE = 2'd0,
    OP_PUSH_EMPTY = 2'd1,
    OP_POP        = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_ELEMENT     = 2'd0,
    ST_EMPTY_LIST  = 2'd1,
    ST_STACK_EMPTY = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic [1:0]         status;
  } out_item_t;

endpackage

/* rtl/core/svl_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_in_if: input channel
// Valid/ready channel that carries one operation per transfer.
// ----------------------------------------------------------------------------
interface svl_in_if;
  logic              valid;
  logic              ready;
  svl_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/svl_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_out_if: result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface svl_out_if;
  logic               valid;
  logic               ready;
  svl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/stack_of_variable_length_lists_top.sv */
`timescale 1ns / 1ps
// Push and empty-list operations give at most one result each.
// A pop first reads the list start from the list-start memory, then
// streams one element per cycle from the element memory while the output is free.
// Input is held off while a pop is in progress or while a result waits at the output.
// Reset (async, active low) empties the stack; memory contents are not cleared.
// ----------------------------------------------------------------------------
// stack_of_variable_length_lists_top: LIFO stack of integer lists
// Lists share one element memory; a second memory holds each list's start.
// ----------------------------------------------------------------------------
module stack_of_variable_length_lists_top #(
  parameter int ELEMENT_DEPTH   = 256,
  parameter int LIST_DEPTH      = 16,
  parameter int MAX_LIST_LENGTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  svl_in_if.sink    in_i,
  svl_out_if.source out_o
);

  localparam int AW = $clog2(ELEMENT_DEPTH);
  localparam int EW = $clog2(ELEMENT_DEPTH + 1);
  localparam int LAW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int OW = $clog2(MAX_LIST_LENGTH + 1);
  localparam int LW = (EW > OW) ? EW : OW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_STREAM
  } state_e;

  state_e                  state_q;
  logic [EW-1:0]           top_q;
  logic [CW-1:0]           count_q;
  logic                    open_q;
  logic [OW-1:0]           olen_q;
  logic [EW-1:0]           rd_idx_q;
  logic [EW-1:0]           rd_end_q;
  logic                    out_valid_q;
  logic                    out_last_q;
  svl_pkg::status_e        out_status_q;

  logic [31:0]             elem_mem [ELEMENT_DEPTH];
  logic [31:0]             elem_rd_q;
  logic [EW-1:0]           start_mem [LIST_DEPTH];
  logic [EW-1:0]           start_rd_q;

  logic                    acc;
  logic                    out_adv;
  logic                    slot_ok;
  logic [OW-1:0]           olen_eff;
  logic                    store_full;
  logic                    len_full;
  logic                    ls_we;
  logic                    el_we;
  logic                    el_re;
  svl_pkg::op_e            op;
  logic [EW-1:0]           start_clip;
  logic [EW-1:0]           pop_diff;
  logic [LW-1:0]           pop_diff_ext;
  logic [LW-1:0]           pop_len;
  logic                    stream_last;

  // Decode the accepted operation
  always_comb begin
    op           = svl_pkg::op_e'(in_i.data.op);
    acc          = in_i.valid && in_i.ready;
    out_adv      = !out_valid_q || out_o.ready;
    slot_ok      = count_q != CW'(LIST_DEPTH);
    olen_eff     = open_q ? olen_q : '0;
    store_full   = top_q == EW'(ELEMENT_DEPTH);
    len_full     = olen_eff == OW'(MAX_LIST_LENGTH);
    ls_we        = acc && slot_ok &&
                   ((op == svl_pkg::OP_PUSH_VALUE && !open_q) ||
                    op == svl_pkg::OP_PUSH_EMPTY);
    el_we        = acc && op == svl_pkg::OP_PUSH_VALUE && (open_q || slot_ok) &&
                   !store_full && !len_full;
    el_re        = state_q == S_STREAM && out_adv;
    start_clip   = (start_rd_q > top_q) ? top_q : start_rd_q;
    pop_diff     = top_q - start_clip;
    pop_diff_ext = LW'(pop_diff);
    pop_len      = (pop_diff_ext > LW'(MAX_LIST_LENGTH)) ? LW'(MAX_LIST_LENGTH)
                                                         : pop_diff_ext;
    stream_last  = EW'(rd_idx_q + 1'b1) == rd_end_q;
  end

  // Element memory: write on push, read while streaming a pop
  always_ff @(posedge clk_i) begin
    if (el_we) begin
      elem_mem[top_q[AW-1:0]] <= in_i.data.value;
    end
    if (el_re) begin
      elem_rd_q <= elem_mem[rd_idx_q[AW-1:0]];
    end
  end

  // List-start memory: write when a list opens, read the top entry every cycle
  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      start_mem[count_q[LAW-1:0]] <= top_q;
    end
    start_rd_q <= start_mem[LAW'(count_q - 1'b1)];
  end

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      top_q        <= '0;
      count_q      <= '0;
      open_q       <= 1'b0;
      olen_q       <= '0;
      rd_idx_q     <= '0;
      rd_end_q     <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= svl_pkg::ST_ELEMENT;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            case (op)
              svl_pkg::OP_PUSH_VALUE: begin
                if (!open_q && !slot_ok) begin
                  out_valid_q  <= 1'b1;
                  out_last_q   <= 1'b1;
                  out_status_q <= svl_pkg::ST_OVERFLOW;
                end else begin
                  if (!open_q) begin
                    count_q <= count_q + 1'b1;
                  end
                  open_q <= !in_i.data.last;
                  if (el_we) begin
                    top_q  <= top_q + 1'b1;
                    olen_q <= olen_eff + 1'b1;
                  end else begin
                    olen_q       <= olen_eff;
                    out_valid_q  <= 1'b1;
                    out_last_q   <= 1'b1;
                    out_status_q <= svl_pkg::ST_OVERFLOW;
                  end
                end
              end
              svl_pkg::OP_PUSH_EMPTY: begin
                open_q <= 1'b0;
                if (slot_ok) begin
                  count_q <= count_q + 1'b1;
                end else begin
                  out_valid_q  <= 1'b1;
                  out_last_q   <= 1'b1;
                  out_status_q <= svl_pkg::ST_OVERFLOW;
                end
              end
              svl_pkg::OP_POP: begin
                open_q <= 1'b0;
                if (count_q == '0) begin
                  out_valid_q  <= 1'b1;
                  out_last_q   <= 1'b1;
                  out_status_q <= svl_pkg::ST_STACK_EMPTY;
                end else begin
                  count_q <= count_q - 1'b1;
                  state_q <= S_START;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // Start entry is now read: size the list and rewind the element top
        S_START: begin
          if (pop_len == '0) begin
            out_valid_q  <= 1'b1;
            out_last_q   <= 1'b1;
            out_status_q <= svl_pkg::ST_EMPTY_LIST;
            state_q      <= S_IDLE;
          end else begin
            rd_idx_q <= start_clip;
            rd_end_q <= EW'(start_clip + EW'(pop_len));
            top_q    <= start_clip;
            state_q  <= S_STREAM;
          end
        end
        // Advance one element per free output slot
        S_STREAM: begin
          if (out_adv) begin
            out_valid_q  <= 1'b1;
            out_last_q   <= stream_last;
            out_status_q <= svl_pkg::ST_ELEMENT;
            rd_idx_q     <= rd_idx_q + 1'b1;
            if (stream_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Drive the channels
  assign in_i.ready = state_q == S_IDLE && out_adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data.value_res = (out_status_q == svl_pkg::ST_ELEMENT) ? elem_rd_q : '0;
  assign out_o.data.last_res = out_last_q;
  assign out_o.data.status = out_status_q;

endmodule

/* rtl/core/svl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_checker: port-level checks for the stack of variable-length lists
// Watches both channels and flags result and flow-control slips.
// ----------------------------------------------------------------------------
module svl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input svl_pkg::out_item_t out_data_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // Drop value and mark final on status-only results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != svl_pkg::ST_ELEMENT |->
      out_data_i.value_res == '0 && out_data_i.last_res)
    else $error("status result carries a value or is not final");

  // Hold input off while a pop still streams
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == svl_pkg::ST_ELEMENT && !out_data_i.last_res |->
      !in_ready_i)
    else $error("input taken in the middle of a pop");

  // Take no input while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("input taken while result stalled");

endmodule

bind stack_of_variable_length_lists_top svl_checker u_svl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
